[src/spq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the sorted priority queue.
// No dependencies.
package spq_pkg;

   localparam int VALUE_WIDTH            = 32;
   localparam int REQ_PRIORITY_WIDTH     = 16;
   localparam int PRIORITY_EXT_WIDTH     = 32;
   localparam int STATUS_WIDTH           = 2;
   localparam int DEPTH_DEFAULT          = 16;
   localparam int PRIORITY_WIDTH_DEFAULT = 16;

   localparam logic CMD_INSERT = 1'b0;

   localparam logic [VALUE_WIDTH-1:0] EMPTY_VALUE = '1;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_INSERTED = 2'd0,
      ST_REMOVED  = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   // operation broadcast to every cell in the chain
   typedef struct packed {
      logic insert;
      logic remove;
   } op_type;

endpackage

[src/sorted_priority_queue_core.sv]
`timescale 1ns / 1ps
// The response to an accepted request is registered and appears in the next cycle.
// Throughput: one transaction per cycle unless a held response stalls requests; every cell compares and shifts at once.
// Cell 0 holds the tail (smallest priority, newest among equals), so a remove reads it.
// Reset: synchronous, clears entry count, cell valid bits and response valid.
// Top level of the sorted priority queue; depends on spq_pkg and spq_cell.
module sorted_priority_queue_core #(
   parameter int DEPTH          = spq_pkg::DEPTH_DEFAULT,
   parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEFAULT,
   localparam int CountWidth    = $clog2(DEPTH + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_command,
   input  logic [spq_pkg::VALUE_WIDTH-1:0]        req_value,
   input  logic [spq_pkg::REQ_PRIORITY_WIDTH-1:0] req_priority_req,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [spq_pkg::VALUE_WIDTH-1:0]        rsp_removed_value,
   output logic [spq_pkg::STATUS_WIDTH-1:0]       rsp_status,
   output logic [CountWidth-1:0]                  rsp_entry_count
);

   logic                                  accept;
   logic                                  is_insert;
   logic                                  full;
   logic                                  empty;
   spq_pkg::op_type                       op;
   logic [spq_pkg::PRIORITY_EXT_WIDTH-1:0] prio_ext;
   logic [PRIORITY_WIDTH-1:0]             new_prio;

   logic [CountWidth-1:0]           count_ff, count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [spq_pkg::VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   spq_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [CountWidth-1:0]           rsp_count_ff;

   logic [DEPTH-1:0]                cell_valid;
   logic [DEPTH-1:0]                cell_below;
   logic [spq_pkg::VALUE_WIDTH-1:0] cell_value [DEPTH];
   logic [PRIORITY_WIDTH-1:0]       cell_prio  [DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_insert = (req_command == spq_pkg::CMD_INSERT);
   assign full      = (count_ff == CountWidth'(DEPTH));
   assign empty     = (count_ff == '0);

   assign op.insert = accept && is_insert && !full;
   assign op.remove = accept && !is_insert && !empty;

   assign prio_ext = {{(spq_pkg::PRIORITY_EXT_WIDTH - spq_pkg::REQ_PRIORITY_WIDTH)
                       {req_priority_req[spq_pkg::REQ_PRIORITY_WIDTH-1]}},
                      req_priority_req};
   assign new_prio = prio_ext[PRIORITY_WIDTH-1:0];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                            lo_below;
      logic                            lo_valid;
      logic [spq_pkg::VALUE_WIDTH-1:0] lo_value;
      logic [PRIORITY_WIDTH-1:0]       lo_prio;
      logic                            hi_valid;
      logic [spq_pkg::VALUE_WIDTH-1:0] hi_value;
      logic [PRIORITY_WIDTH-1:0]       hi_prio;

      if (i == 0) begin : g_lo_edge
         assign lo_below = 1'b1;
         assign lo_valid = 1'b0;
         assign lo_value = '0;
         assign lo_prio  = '0;
      end else begin : g_lo_link
         assign lo_below = cell_below[i-1];
         assign lo_valid = cell_valid[i-1];
         assign lo_value = cell_value[i-1];
         assign lo_prio  = cell_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_hi_edge
         assign hi_valid = 1'b0;
         assign hi_value = '0;
         assign hi_prio  = '0;
      end else begin : g_hi_link
         assign hi_valid = cell_valid[i+1];
         assign hi_value = cell_value[i+1];
         assign hi_prio  = cell_prio[i+1];
      end

      spq_cell #(
         .PRIORITY_WIDTH(PRIORITY_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .op       (op),
         .new_value(req_value),
         .new_prio (new_prio),
         .lo_below (lo_below),
         .lo_valid (lo_valid),
         .lo_value (lo_value),
         .lo_prio  (lo_prio),
         .hi_valid (hi_valid),
         .hi_value (hi_value),
         .hi_prio  (hi_prio),
         .valid    (cell_valid[i]),
         .value    (cell_value[i]),
         .prio     (cell_prio[i]),
         .below    (cell_below[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (op.insert) begin
         count_in = count_ff + CountWidth'(1);
      end else if (op.remove) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      if (is_insert) begin
         rsp_value_in  = '0;
         rsp_status_in = full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
      end else if (empty) begin
         rsp_value_in  = spq_pkg::EMPTY_VALUE;
         rsp_status_in = spq_pkg::ST_EMPTY;
      end else begin
         rsp_value_in  = cell_value[0];
         rsp_status_in = spq_pkg::ST_REMOVED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_value_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_count   = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(DEPTH))
      else $error("entry count above depth");

   a_valid_matches_count: assert property (@(posedge clock) disable iff (reset)
      count_ff == CountWidth'($countones(cell_valid)))
      else $error("cell valid bits disagree with entry count");

   a_tail_valid: assert property (@(posedge clock) disable iff (reset)
      cell_valid[0] == (count_ff != '0))
      else $error("tail cell valid disagrees with entry count");

   a_full_no_change: assert property (@(posedge clock) disable iff (reset)
      (accept && is_insert && full) |=> (count_ff == $past(count_ff)))
      else $error("dropped insert changed entry count");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      op.remove |=> (rsp_entry_count == $past(count_ff) - CountWidth'(1)))
      else $error("remove reported wrong entry count");

endmodule

[src/spq_cell.sv]
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell #(
   parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  spq_pkg::op_type                 op,
   input  logic [spq_pkg::VALUE_WIDTH-1:0] new_value,
   input  logic [PRIORITY_WIDTH-1:0]       new_prio,
   input  logic                            lo_below,
   input  logic                            lo_valid,
   input  logic [spq_pkg::VALUE_WIDTH-1:0] lo_value,
   input  logic [PRIORITY_WIDTH-1:0]       lo_prio,
   input  logic                            hi_valid,
   input  logic [spq_pkg::VALUE_WIDTH-1:0] hi_value,
   input  logic [PRIORITY_WIDTH-1:0]       hi_prio,
   output logic                            valid,
   output logic [spq_pkg::VALUE_WIDTH-1:0] value,
   output logic [PRIORITY_WIDTH-1:0]       prio,
   output logic                            below
);

   logic                            valid_ff, valid_in;
   logic [spq_pkg::VALUE_WIDTH-1:0] value_ff, value_in;
   logic [PRIORITY_WIDTH-1:0]       prio_ff, prio_in;

   // entry stays put on insert when it sorts strictly below the new one
   assign below = valid_ff && ($signed(prio_ff) < $signed(new_prio));

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      prio_in  = prio_ff;
      if (op.insert) begin
         if (!below) begin
            if (lo_below) begin
               valid_in = 1'b1;
               value_in = new_value;
               prio_in  = new_prio;
            end else begin
               valid_in = lo_valid;
               value_in = lo_value;
               prio_in  = lo_prio;
            end
         end
      end else if (op.remove) begin
         valid_in = hi_valid;
         value_in = hi_value;
         prio_in  = hi_prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign prio  = prio_ff;

endmodule
